// ----- hw/rtl/point_list_table_core_assert.svh -----
// Assertion macros for the point list table core.
// Included by files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef POINT_LIST_TABLE_CORE_ASSERT_SVH
`define POINT_LIST_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PLT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("point list table check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("point list table check failed");

`endif

// ----- hw/rtl/plt_pkg.sv -----
// Shared types, sizes and codes for the point list table core.
// No dependencies; imported by every module of the block.
package plt_pkg;

  localparam int CAPACITY   = 16;
  localparam int COORD_BITS = 16;
  localparam int SLOT_W     = 4;
  localparam int COUNT_W    = 5;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int EXT_W      = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    CMD_APPEND    = 3'd0,
    CMD_DELETE    = 3'd1,
    CMD_READ      = 3'd2,
    CMD_OVERWRITE = 3'd3,
    CMD_FIND      = 3'd4,
    CMD_CLEAR     = 3'd5
  } plt_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } plt_status_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } plt_point_t;

  typedef struct packed {
    logic shift;
    logic load;
  } plt_cell_ctrl_t;

endpackage

// ----- hw/rtl/plt_cell.sv -----
// One storage cell of the point chain: holds a point, takes its upper neighbor on shift.
// Depends on plt_pkg.
module plt_cell
  import plt_pkg::*;
(
  input  logic           clk_i,
  input  plt_cell_ctrl_t ctrl_i,
  input  plt_point_t     wr_pt_i,
  input  plt_point_t     nbr_pt_i,
  output plt_point_t     pt_o,
  output logic           match_o
);

  plt_point_t pt_q, pt_d;

  always_comb begin
    pt_d = pt_q;
    if (ctrl_i.shift) begin
      pt_d = nbr_pt_i;
    end else if (ctrl_i.load) begin
      pt_d = wr_pt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end

  assign pt_o    = pt_q;
  assign match_o = (pt_q == wr_pt_i);

endmodule

// ----- hw/rtl/plt_prienc.sv -----
// Lowest-set-bit priority encoder over the per-cell match flags.
// Depends on plt_pkg.
module plt_prienc
  import plt_pkg::*;
(
  input  logic [CAPACITY-1:0] req_i,
  output logic                found_o,
  output logic [IDX_W-1:0]    idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (req_i[i]) begin
        found_o = 1'b1;
        idx_o   = IDX_W'(i);
      end
    end
  end

endmodule

// ----- hw/rtl/point_list_table_core.sv -----
// Point list table core: each accepted word's result is registered in the result register.
// Throughput one word per cycle; the input is taken while a result waits, as long as
// the result register is empty or drains in the same cycle.
// Every command, delete shift included, completes at the clock edge that accepts it,
// since each cell of the chain updates in parallel.
// Reset clears the fill count and output valid; stored points stay undefined until written.
module point_list_table_core
  import plt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // s_axis_tdata fields, low bit up: cmd[2:0], slot[6:3], in_x[22:7], in_y[38:23], pad
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // m_axis_tdata fields, low bit up: status[1:0], out_x[17:2], out_y[33:18],
  // match_slot[37:34], count[42:38], empty_res[43], pad
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  `include "point_list_table_core_assert.svh"

  // Unpack the input word.
  logic [2:0]            cmd;
  logic [SLOT_W-1:0]     slot;
  plt_point_t            in_pt;

  assign cmd      = s_axis_tdata_i[2:0];
  assign slot     = s_axis_tdata_i[6:3];
  assign in_pt.x  = s_axis_tdata_i[22:7];
  assign in_pt.y  = s_axis_tdata_i[38:23];

  // Control state.
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             m_valid_q, m_valid_d;
  logic             accept;

  // Result register fields.
  plt_status_e           res_status_q, res_status_d;
  plt_point_t            res_pt_q, res_pt_d;
  logic [SLOT_W-1:0]     res_match_q, res_match_d;
  logic [COUNT_W-1:0]    res_count_q, res_count_d;
  logic                  res_empty_q, res_empty_d;

  // Accept a new word whenever the result register is free or being taken now.
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Index checks in a common width so narrow or wide capacities both compare correctly.
  logic [EXT_W-1:0] slot_ext, fill_ext;
  logic             slot_ok, full;

  assign slot_ext = EXT_W'(slot);
  assign fill_ext = EXT_W'(fill_q);
  assign slot_ok  = (slot_ext < fill_ext) && (slot_ext < EXT_W'(CAPACITY));
  assign full     = (fill_ext >= EXT_W'(CAPACITY));

  // Cell chain: cell i takes cell i+1 on a delete shift; the top cell refeeds itself.
  plt_cell_ctrl_t        cell_ctrl [CAPACITY];
  plt_point_t            cell_pt   [CAPACITY];
  logic [CAPACITY-1:0]   cell_match;
  logic [CAPACITY-1:0]   find_req;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    plt_point_t nbr_pt;
    if (g == CAPACITY - 1) begin : g_top
      assign nbr_pt = cell_pt[g];
    end else begin : g_mid
      assign nbr_pt = cell_pt[g + 1];
    end

    always_comb begin
      cell_ctrl[g].shift = accept && (cmd == CMD_DELETE) && slot_ok
                           && (EXT_W'(g) >= slot_ext);
      cell_ctrl[g].load  = accept
                           && (((cmd == CMD_APPEND) && !full && (EXT_W'(g) == fill_ext))
                            || ((cmd == CMD_OVERWRITE) && slot_ok && (EXT_W'(g) == slot_ext)));
    end

    plt_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl[g]),
      .wr_pt_i  (in_pt),
      .nbr_pt_i (nbr_pt),
      .pt_o     (cell_pt[g]),
      .match_o  (cell_match[g])
    );

    // Only occupied cells may answer a find.
    assign find_req[g] = cell_match[g] && (EXT_W'(g) < fill_ext);
  end

  logic             find_hit;
  logic [IDX_W-1:0] find_idx;

  plt_prienc u_prienc (
    .req_i   (find_req),
    .found_o (find_hit),
    .idx_o   (find_idx)
  );

  // Read mux across the chain.
  plt_point_t rd_pt;

  always_comb begin
    rd_pt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_ext == EXT_W'(i)) begin
        rd_pt = cell_pt[i];
      end
    end
  end

  // Command decode: next fill count and the result word.
  always_comb begin
    fill_d       = fill_q;
    res_status_d = ST_OK;
    res_pt_d     = '0;
    res_match_d  = '0;
    unique case (cmd)
      CMD_APPEND: begin
        if (full) begin
          res_status_d = ST_FULL;
        end else begin
          fill_d = fill_q + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (slot_ok) begin
          fill_d = fill_q - CNT_W'(1);
        end else begin
          res_status_d = ST_BAD_INDEX;
        end
      end
      CMD_READ: begin
        if (slot_ok) begin
          res_pt_d = rd_pt;
        end else begin
          res_status_d = ST_BAD_INDEX;
        end
      end
      CMD_OVERWRITE: begin
        if (!slot_ok) begin
          res_status_d = ST_BAD_INDEX;
        end
      end
      CMD_FIND: begin
        if (find_hit) begin
          res_match_d = SLOT_W'(find_idx);
        end else begin
          res_status_d = ST_NOT_FOUND;
        end
      end
      CMD_CLEAR: begin
        fill_d = '0;
      end
      default: begin
        // Unused codes: hold state, report ok.
      end
    endcase
    res_count_d = COUNT_W'(fill_d);
    res_empty_d = (fill_d == '0);
  end

  // Hold valid until taken; load a fresh word on accept.
  always_comb begin
    m_valid_d = m_valid_q;
    if (accept) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      if (accept) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q <= res_status_d;
      res_pt_q     <= res_pt_d;
      res_match_q  <= res_match_d;
      res_count_q  <= res_count_d;
      res_empty_q  <= res_empty_d;
    end
  end

  // Pack the output word.
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0000, res_empty_q, res_count_q, res_match_q,
                            res_pt_q.y, res_pt_q.x, res_status_q};

  // Checks.
  `PLT_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CNT_W'(CAPACITY))
  `PLT_ASSERT_NEXT(a_append_grows, accept && (cmd == CMD_APPEND) && !full,
                   fill_q == $past(fill_q) + CNT_W'(1))
  `PLT_ASSERT_IMPL(a_empty_flag, m_valid_q, res_empty_q == (res_count_q == '0))
  `PLT_ASSERT_IMPL(a_miss_slot_zero, m_valid_q && (res_status_q == ST_NOT_FOUND),
                   res_match_q == '0)

endmodule

// ----- verif/tb_point_list_table_core.sv -----
// Self-checking testbench for point_list_table_core: directed and random command words
// with random idle gaps on both stream sides, checked against a shadow list kept here.
// Depends on plt_pkg and point_list_table_core only.
`timescale 1ns / 1ps

module tb_point_list_table_core;
  import plt_pkg::*;

  localparam int          RANDOM_ITEMS = 610;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          MAX_REPORTS  = 10;
  // cmd codes 6 and 7 are decoded as no-ops by the block
  localparam logic [2:0]  CMD_SPARE_LO = 3'd6;
  localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
  // random traffic phases
  localparam int          PH_GROW      = 0;
  localparam int          PH_SHRINK    = 1;
  localparam int          PH_MIXED     = 2;

  typedef struct {
    plt_status_e           status;
    logic [COORD_BITS-1:0] rd_x;
    logic [COORD_BITS-1:0] rd_y;
    logic [SLOT_W-1:0]     hit_slot;
    logic [COUNT_W-1:0]    count;
    logic                  empty;
  } list_response_t;

  // Shadow copy of the point list; predicts one response per accepted command word.
  class point_list_shadow;
    plt_point_t     cells[CAPACITY];
    int unsigned    fill;
    list_response_t pending_responses[$];
    int unsigned    mismatches;
    int unsigned    responses_ok;
    int unsigned    n_full, n_bad, n_miss, n_hit;

    function new();
      fill = 0;
      mismatches = 0;
      responses_ok = 0;
      n_full = 0; n_bad = 0; n_miss = 0; n_hit = 0;
    endfunction

    function void note_command(logic [2:0] cmd, logic [SLOT_W-1:0] slot, plt_point_t pt);
      list_response_t r;
      bit             slot_ok;
      r.status   = ST_OK;
      r.rd_x     = '0;
      r.rd_y     = '0;
      r.hit_slot = '0;
      slot_ok    = slot < fill;
      case (cmd)
        CMD_APPEND: begin
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            cells[fill] = pt;
            fill++;
          end
        end
        CMD_DELETE: begin
          if (!slot_ok) begin
            r.status = ST_BAD_INDEX;
          end else begin
            // close the gap: later entries move down one place
            for (int i = slot; i + 1 < fill; i++) cells[i] = cells[i + 1];
            fill--;
          end
        end
        CMD_READ: begin
          if (!slot_ok) begin
            r.status = ST_BAD_INDEX;
          end else begin
            r.rd_x = cells[slot].x;
            r.rd_y = cells[slot].y;
          end
        end
        CMD_OVERWRITE: begin
          if (!slot_ok) r.status = ST_BAD_INDEX;
          else cells[slot] = pt;
        end
        CMD_FIND: begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < fill; i++) begin
            if (cells[i] == pt) begin
              r.status   = ST_OK;
              r.hit_slot = i[SLOT_W-1:0];
              break;
            end
          end
          if (r.status == ST_OK) n_hit++;
          else n_miss++;
        end
        CMD_CLEAR: fill = 0;
        default: ;
      endcase
      if (r.status == ST_FULL) n_full++;
      if (r.status == ST_BAD_INDEX) n_bad++;
      r.count = fill[COUNT_W-1:0];
      r.empty = (fill == 0);
      pending_responses.push_back(r);
    endfunction

    function void check_response(logic [OUT_DATA_W-1:0] d);
      list_response_t want;
      list_response_t got;
      got.status   = plt_status_e'(d[1:0]);
      got.rd_x     = d[17:2];
      got.rd_y     = d[33:18];
      got.hit_slot = d[37:34];
      got.count    = d[42:38];
      got.empty    = d[43];
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: response error: word 0x%h arrived with none outstanding", $time, d);
        return;
      end
      want = pending_responses.pop_front();
      if (got.status != want.status || got.rd_x != want.rd_x || got.rd_y != want.rd_y ||
          got.hit_slot != want.hit_slot || got.count != want.count ||
          got.empty != want.empty) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: response error: exp st=%0d x=%h y=%h slot=%0d cnt=%0d empty=%0b",
                   $time, want.status, want.rd_x, want.rd_y, want.hit_slot, want.count,
                   want.empty);
          $display("%0t:                 got st=%0d x=%h y=%h slot=%0d cnt=%0d empty=%0b",
                   $time, got.status, got.rd_x, got.rd_y, got.hit_slot, got.count,
                   got.empty);
        end
      end else begin
        responses_ok++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // cmd[2:0], slot[6:3], in_x[22:7], in_y[38:23], pad
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // status, out_x, out_y, match_slot, count, empty_res

  point_list_shadow shadow;
  int unsigned      idle_cycles;
  int unsigned      words_sent;
  bit               rx_calm;

  point_list_table_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Mostly short gaps, some long ones; calm stretches have none at all.
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Small pool of corner points so that duplicates and find hits are common.
  function automatic plt_point_t pool_point(int k);
    plt_point_t p;
    case (k)
      0: p = '{x: 16'h0000, y: 16'h0000};
      1: p = '{x: 16'h8000, y: 16'h7fff};
      2: p = '{x: 16'h7fff, y: 16'h8000};
      3: p = '{x: 16'hffff, y: 16'hffff};
      4: p = '{x: 16'h0001, y: 16'hffff};
      5: p = '{x: 16'h7fff, y: 16'h7fff};
      6: p = '{x: 16'h8000, y: 16'h8000};
      default: p = '{x: 16'h0005, y: 16'h0005};
    endcase
    return p;
  endfunction

  function automatic plt_point_t pick_point();
    plt_point_t p;
    if ($urandom_range(0, 99) < 35) begin
      p = pool_point($urandom_range(0, 7));
    end else begin
      p.x = COORD_BITS'($urandom());
      p.y = COORD_BITS'($urandom());
    end
    return p;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    if (shadow.fill > 0 && $urandom_range(0, 9) < 8)
      return SLOT_W'($urandom_range(0, shadow.fill - 1));
    return SLOT_W'($urandom_range(0, CAPACITY - 1));
  endfunction

  // Present one command word and hold it until the block takes it.
  task automatic push_cmd(logic [2:0] cmd, logic [SLOT_W-1:0] slot, plt_point_t pt);
    int gap;
    gap = pick_gap(1'b0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, pt.y, pt.x, slot, cmd};
    do @(posedge clk_i); while (!s_tready);
    shadow.note_command(cmd, slot, pt);
    words_sent++;
  endtask

  task automatic push_random_cmd(int phase);
    int          r;
    int          wa, wd, wr, wo, wf, wc;
    logic [2:0]  cmd;
    plt_point_t  pt;
    r = $urandom_range(0, 99);
    case (phase)
      PH_GROW:   begin wa = 62; wd = 6;  wr = 10; wo = 8;  wf = 10; wc = 1; end
      PH_SHRINK: begin wa = 8;  wd = 45; wr = 15; wo = 10; wf = 16; wc = 3; end
      default:   begin wa = 25; wd = 20; wr = 18; wo = 12; wf = 20; wc = 2; end
    endcase
    if (r < wa) cmd = CMD_APPEND;
    else if (r < wa + wd) cmd = CMD_DELETE;
    else if (r < wa + wd + wr) cmd = CMD_READ;
    else if (r < wa + wd + wr + wo) cmd = CMD_OVERWRITE;
    else if (r < wa + wd + wr + wo + wf) cmd = CMD_FIND;
    else if (r < wa + wd + wr + wo + wf + wc) cmd = CMD_CLEAR;
    else cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    pt = pick_point();
    // aim most finds at a stored point, so hits and lowest-match priority get exercised
    if (cmd == CMD_FIND && shadow.fill > 0 && $urandom_range(0, 99) < 60)
      pt = shadow.cells[$urandom_range(0, shadow.fill - 1)];
    push_cmd(cmd, pick_slot(), pt);
  endtask

  // Receiver side: random backpressure with calm stretches.
  initial begin
    int run_len;
    int stall;
    m_tready <= 1'b0;
    rx_calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_calm = ~rx_calm;
      run_len = $urandom_range(1, 12);
      m_tready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      stall = pick_gap(rx_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Check every response at the edge it is taken.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) shadow.check_response(m_tdata);
  end

  // Stop a hung run: count cycles with no handshake on either side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog: no word moved in %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int valid_cmds;
    int phase;
    int phase_left;
    shadow     = new();
    words_sent = 0;
    rst_ni     <= 1'b0;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, extreme coordinates, duplicates, shifts, spare codes, clear.
    push_cmd(CMD_READ,      4'd0,  pool_point(0));
    push_cmd(CMD_DELETE,    4'd0,  pool_point(0));
    push_cmd(CMD_FIND,      4'd0,  pool_point(0));
    push_cmd(CMD_OVERWRITE, 4'd15, pool_point(5));
    push_cmd(CMD_APPEND,    4'd0,  pool_point(1));
    push_cmd(CMD_APPEND,    4'd0,  pool_point(2));
    push_cmd(CMD_APPEND,    4'd0,  pool_point(0));
    push_cmd(CMD_APPEND,    4'd0,  pool_point(3));
    push_cmd(CMD_APPEND,    4'd0,  pool_point(2));
    push_cmd(CMD_READ,      4'd4,  pool_point(0));
    push_cmd(CMD_READ,      4'd5,  pool_point(0));
    push_cmd(CMD_FIND,      4'd0,  pool_point(2));
    push_cmd(CMD_FIND,      4'd0,  pool_point(4));
    push_cmd(CMD_OVERWRITE, 4'd1,  '{x: 16'h1234, y: 16'hfffe});
    push_cmd(CMD_FIND,      4'd0,  pool_point(2));
    push_cmd(CMD_DELETE,    4'd0,  pool_point(0));
    push_cmd(CMD_READ,      4'd0,  pool_point(0));
    push_cmd(CMD_DELETE,    4'd3,  pool_point(0));
    push_cmd(CMD_DELETE,    4'd15, pool_point(0));
    push_cmd(CMD_SPARE_LO,  4'd0,  pool_point(6));
    push_cmd(CMD_SPARE_HI,  4'd9,  pool_point(7));
    push_cmd(CMD_CLEAR,     4'd0,  pool_point(0));
    push_cmd(CMD_READ,      4'd0,  pool_point(0));
    push_cmd(CMD_FIND,      4'd0,  pool_point(0));

    // Random: start by growing so the full list is reached early, then wander.
    valid_cmds = 0;
    phase      = PH_GROW;
    phase_left = 40;
    while (valid_cmds < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase      = $urandom_range(PH_GROW, PH_MIXED);
        phase_left = $urandom_range(15, 60);
      end
      push_random_cmd(phase);
      phase_left--;
      if (s_tdata[2:0] <= CMD_CLEAR) valid_cmds++;
    end
    s_tvalid <= 1'b0;

    // Drain, then give stray responses a chance to show up.
    while (shadow.pending_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run: %0d command words, %0d responses matched, %0d mismatched",
             words_sent, shadow.responses_ok, shadow.mismatches);
    $display("Cases: %0d full-list appends, %0d bad indexes, %0d find hits, %0d find misses",
             shadow.n_full, shadow.n_bad, shadow.n_hit, shadow.n_miss);
    if (shadow.mismatches == 0 && shadow.pending_responses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/plt_pkg.sv
hw/rtl/plt_cell.sv
hw/rtl/plt_prienc.sv
hw/rtl/point_list_table_core.sv
verif/tb_point_list_table_core.sv
